/* sv/sfdl_pkg.sv */
// ----------------------------------------------------------------------------
// sfdl_pkg
// Shared types and constants for the smoothed fractional delay line.
// ----------------------------------------------------------------------------
package sfdl_pkg;

  localparam int TGT_W    = 10;   // target delay input width
  localparam int RATE_NUM = 66;   // glide rate numerator over 2^16
  localparam int RATE_SH  = 16;
  localparam int SNAP_DEN = 100;  // snap when |delta| * 100 < 1.0

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIFF,
    F_STEP,
    F_POS
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SEL,
    B_MUL,
    B_PUSH
  } back_state_e;

endpackage

/* sv/sfdl_fifo.sv */
// ----------------------------------------------------------------------------
// sfdl_fifo
// Two-entry register queue; head is always presented on rdata_o.
// ----------------------------------------------------------------------------
module sfdl_fifo #(
  parameter int WIDTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [WIDTH-1:0]    wdata_i,
  input  logic                pop_i,
  output logic [WIDTH-1:0]    rdata_o,
  output sfdl_pkg::fifo_stat_t stat_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rdata_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

/* sv/sfdl_front.sv */
// ----------------------------------------------------------------------------
// sfdl_front
// Accepts a sample beat, glides the current delay toward the target and
// computes the fractional read position, then queues the job for the back end.
// ----------------------------------------------------------------------------
module sfdl_front #(
  parameter int MAX_DELAY   = 1023,
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS   = 16,
  localparam int AW = $clog2(MAX_DELAY + 1),
  localparam int EW = SAMPLE_BITS + 3 * AW + FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [SAMPLE_BITS-1:0]       sample_i,
  input  logic                         tgt_we_i,
  input  logic [sfdl_pkg::TGT_W-1:0]   tgt_i,
  input  sfdl_pkg::fifo_stat_t         q_stat_i,
  output logic                         q_push_o,
  output logic [EW-1:0]                q_data_o
);

  localparam int DW = AW + FRAC_BITS;
  localparam int MW = DW + 7;
  localparam logic [AW-1:0] LAST = AW'(MAX_DELAY);
  localparam logic [DW:0]   SPAN = (DW + 1)'(MAX_DELAY + 1) << FRAC_BITS;
  localparam logic [MW-1:0] ONE  = MW'(1) << FRAC_BITS;
  localparam logic [MW-1:0] HALF = MW'(1) << (sfdl_pkg::RATE_SH - 1);

  sfdl_pkg::front_state_e state_q, state_d;

  logic [AW-1:0]          target_q, wp_q, wp_next;
  logic [DW-1:0]          cur_q, cur_d, mag_q, mag_d, tq, step;
  logic                   up_q, eq_q, up_d;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [MW-1:0]          mag_x, step_full;
  logic                   snap, accept;
  logic [DW:0]            wbase, pos_w;
  logic [DW-1:0]          pos;
  logic [AW-1:0]          idx, nidx;
  logic [FRAC_BITS-1:0]   frac;

  assign tq      = {target_q, {FRAC_BITS{1'b0}}};
  assign accept  = push_i && (state_q == sfdl_pkg::F_IDLE);
  assign wp_next = (wp_q == LAST) ? '0 : wp_q + 1'b1;

  // difference toward target
  always_comb begin
    up_d  = tq > cur_q;
    mag_d = up_d ? tq - cur_q : cur_q - tq;
  end

  // glide step: round(|delta| * 66 / 2^16), or snap
  always_comb begin
    mag_x     = MW'(mag_q);
    snap      = (mag_x * MW'(sfdl_pkg::SNAP_DEN)) < ONE;
    step_full = (mag_x * MW'(sfdl_pkg::RATE_NUM) + HALF) >> sfdl_pkg::RATE_SH;
    step      = step_full[DW-1:0];
    if (eq_q) begin
      cur_d = cur_q;
    end else if (snap) begin
      cur_d = tq;
    end else if (up_q) begin
      cur_d = cur_q + step;
    end else begin
      cur_d = cur_q - step;
    end
  end

  // read position = write pointer - delay, wrapped
  always_comb begin
    wbase = {1'b0, wp_q, {FRAC_BITS{1'b0}}};
    if ({1'b0, cur_q} <= wbase) begin
      pos_w = wbase - {1'b0, cur_q};
    end else begin
      pos_w = wbase + SPAN - {1'b0, cur_q};
    end
    pos  = pos_w[DW-1:0];
    idx  = pos[DW-1:FRAC_BITS];
    frac = pos[FRAC_BITS-1:0];
    nidx = (idx == LAST) ? '0 : idx + 1'b1;
  end

  always_comb begin
    case (state_q)
      sfdl_pkg::F_IDLE: state_d = push_i ? sfdl_pkg::F_DIFF : sfdl_pkg::F_IDLE;
      sfdl_pkg::F_DIFF: state_d = sfdl_pkg::F_STEP;
      sfdl_pkg::F_STEP: state_d = sfdl_pkg::F_POS;
      sfdl_pkg::F_POS:  state_d = q_stat_i.full ? sfdl_pkg::F_POS : sfdl_pkg::F_IDLE;
      default:          state_d = sfdl_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    full_o   = (state_q != sfdl_pkg::F_IDLE);
    q_push_o = (state_q == sfdl_pkg::F_POS) && !q_stat_i.full;
    q_data_o = {sample_q, wp_q, idx, nidx, frac};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sfdl_pkg::F_IDLE;
      target_q <= '0;
      cur_q    <= '0;
      wp_q     <= '0;
    end else begin
      state_q <= state_d;
      if (tgt_we_i && (32'(tgt_i) < 32'(MAX_DELAY))) target_q <= AW'(tgt_i);
      if (state_q == sfdl_pkg::F_STEP) cur_q <= cur_d;
      if (q_push_o) wp_q <= wp_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) sample_q <= sample_i;
    if (state_q == sfdl_pkg::F_DIFF) begin
      mag_q <= mag_d;
      up_q  <= up_d;
      eq_q  <= (tq == cur_q);
    end
  end

endmodule

/* sv/sfdl_back.sv */
// ----------------------------------------------------------------------------
// sfdl_back
// Writes the sample into the ring, reads both neighbors and interpolates.
// Never-written ring entries read as zero through a fill count.
// ----------------------------------------------------------------------------
module sfdl_back #(
  parameter int MAX_DELAY   = 1023,
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS   = 16,
  localparam int AW = $clog2(MAX_DELAY + 1),
  localparam int EW = SAMPLE_BITS + 3 * AW + FRAC_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sfdl_pkg::fifo_stat_t   q_stat_i,
  input  logic [EW-1:0]          q_data_i,
  output logic                   q_pop_o,
  input  sfdl_pkg::fifo_stat_t   o_stat_i,
  output logic                   o_push_o,
  output logic [SAMPLE_BITS-1:0] o_data_o
);

  localparam int RING = MAX_DELAY + 1;
  localparam int SB   = SAMPLE_BITS;
  localparam int PW   = SB + FRAC_BITS + 2;
  localparam logic [AW:0]          RING_N = (AW + 1)'(RING);
  localparam logic signed [PW-1:0] HALF   = PW'(1) << (FRAC_BITS - 1);

  sfdl_pkg::back_state_e state_q, state_d;

  logic [SB-1:0]        ring_q [RING];
  logic [SB-1:0]        rd1_q, rd2_q, sample_q;
  logic [AW:0]          fill_q;
  logic [FRAC_BITS-1:0] frac_q;
  logic                 h1_q, v1_q, h2_q, v2_q;
  logic signed [SB-1:0] s1_q, s1, s2;
  logic signed [SB:0]   diff_q, diff_d;
  logic signed [PW-1:0] prod_q, prod_d, sum;

  logic [SB-1:0]        e_sample;
  logic [AW-1:0]        e_wp, e_idx, e_nidx;
  logic [FRAC_BITS-1:0] e_frac;
  logic                 issue;

  assign {e_sample, e_wp, e_idx, e_nidx, e_frac} = q_data_i;

  always_comb begin
    s1 = h1_q ? sample_q : (v1_q ? rd1_q : '0);
    s2 = h2_q ? sample_q : (v2_q ? rd2_q : '0);
    diff_d = (SB + 1)'(s2) - (SB + 1)'(s1);
    prod_d = PW'(diff_q) * PW'($signed({1'b0, frac_q})) + HALF;
    sum    = PW'(s1_q) + (prod_q >>> FRAC_BITS);
  end

  always_comb begin
    case (state_q)
      sfdl_pkg::B_IDLE: issue = !q_stat_i.empty;
      sfdl_pkg::B_PUSH: issue = !q_stat_i.empty && !o_stat_i.full;
      default:          issue = 1'b0;
    endcase
    q_pop_o  = issue;
    o_push_o = (state_q == sfdl_pkg::B_PUSH) && !o_stat_i.full;
    o_data_o = sum[SB-1:0];
  end

  always_comb begin
    case (state_q)
      sfdl_pkg::B_IDLE: state_d = issue ? sfdl_pkg::B_SEL : sfdl_pkg::B_IDLE;
      sfdl_pkg::B_SEL:  state_d = sfdl_pkg::B_MUL;
      sfdl_pkg::B_MUL:  state_d = sfdl_pkg::B_PUSH;
      sfdl_pkg::B_PUSH: begin
        if (o_stat_i.full) begin
          state_d = sfdl_pkg::B_PUSH;
        end else begin
          state_d = issue ? sfdl_pkg::B_SEL : sfdl_pkg::B_IDLE;
        end
      end
      default:          state_d = sfdl_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfdl_pkg::B_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      if (issue && (fill_q != RING_N)) fill_q <= fill_q + 1'b1;
    end
  end

  // ring: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (issue) begin
      ring_q[e_wp] <= e_sample;
      rd1_q        <= ring_q[e_idx];
      rd2_q        <= ring_q[e_nidx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      sample_q <= e_sample;
      frac_q   <= e_frac;
      h1_q     <= (e_idx == e_wp);
      h2_q     <= (e_nidx == e_wp);
      v1_q     <= ({1'b0, e_idx} < fill_q);
      v2_q     <= ({1'b0, e_nidx} < fill_q);
    end
    if (state_q == sfdl_pkg::B_SEL) begin
      s1_q   <= s1;
      diff_q <= diff_d;
    end
    if (state_q == sfdl_pkg::B_MUL) prod_q <= prod_d;
  end

endmodule

/* sv/smoothed_fractional_delay_line.sv */
// ----------------------------------------------------------------------------
// smoothed_fractional_delay_line
// Variable audio delay with gliding delay and linear interpolation.
// ----------------------------------------------------------------------------
// A sample beat passes through the front end (accept, delay difference,
// glide step, read position) and then the back end (ring write with both
// neighbor reads, select, multiply, round and add). The two ends overlap
// through a two-entry job queue, so unless the output queue backs up, the
// sustained rate is set by the front end's glide sequence, which takes no new
// sample until the last one is queued. Ring entries not yet written read as
// zero via a fill count, so there is no clearing pass after reset.
// target_delay_i is taken when target_delay_we_i is high; values of
// MAX_DELAY or more are ignored.
module smoothed_fractional_delay_line #(
  parameter int MAX_DELAY   = 1023,
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [SAMPLE_BITS-1:0]     sample_in_i,
  input  logic                       target_delay_we_i,
  input  logic [sfdl_pkg::TGT_W-1:0] target_delay_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [SAMPLE_BITS-1:0]     sample_out_o
);

  localparam int AW = $clog2(MAX_DELAY + 1);
  localparam int EW = SAMPLE_BITS + 3 * AW + FRAC_BITS;

  sfdl_pkg::fifo_stat_t   job_stat, out_stat;
  logic                   job_push, job_pop, out_push;
  logic [EW-1:0]          job_wdata, job_rdata;
  logic [SAMPLE_BITS-1:0] out_wdata;

  sfdl_front #(
    .MAX_DELAY  (MAX_DELAY),
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .sample_i(sample_in_i),
    .tgt_we_i(target_delay_we_i),
    .tgt_i   (target_delay_i),
    .q_stat_i(job_stat),
    .q_push_o(job_push),
    .q_data_o(job_wdata)
  );

  sfdl_fifo #(.WIDTH(EW)) u_job_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .wdata_i(job_wdata),
    .pop_i  (job_pop),
    .rdata_o(job_rdata),
    .stat_o (job_stat)
  );

  sfdl_back #(
    .MAX_DELAY  (MAX_DELAY),
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_stat_i(job_stat),
    .q_data_i(job_rdata),
    .q_pop_o (job_pop),
    .o_stat_i(out_stat),
    .o_push_o(out_push),
    .o_data_o(out_wdata)
  );

  sfdl_fifo #(.WIDTH(SAMPLE_BITS)) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .wdata_i(out_wdata),
    .pop_i  (pop),
    .rdata_o(sample_out_o),
    .stat_o (out_stat)
  );

  assign empty = out_stat.empty;

endmodule

/* sv/sfdl_checker.sv */
// ----------------------------------------------------------------------------
// sfdl_checker
// Port-level checks for the smoothed fractional delay line.
// ----------------------------------------------------------------------------
module sfdl_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   push,
  input logic                   full,
  input logic                   empty,
  input logic                   pop,
  input logic [SAMPLE_BITS-1:0] sample_out_o
);

  logic [3:0] cnt_q;
  logic       in_beat, out_beat;

  assign in_beat  = push && !full;
  assign out_beat = pop && !empty;

  // beats in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 4'd0;
    end else begin
      case ({in_beat, out_beat})
        2'b10:   cnt_q <= cnt_q + 4'd1;
        2'b01:   cnt_q <= cnt_q - 4'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> full ##1 full ##1 full)
    else $error("front end took a new beat before its sequence ended");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 4'd0) |-> empty)
    else $error("result shown with no beat in flight");

  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'd6)
    else $error("more beats in flight than the block can hold");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(sample_out_o)))
    else $error("waiting result changed or vanished");

endmodule

bind smoothed_fractional_delay_line sfdl_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_sfdl_checker (.*);
